// ===== hw/rtl/ldma_pkg.sv =====
// Shared types, codes and constants for the line detector.
// Used by the top level and by the evaluation logic; depends on nothing.
package ldma_pkg;

  localparam int READ_W     = 10;
  localparam int ANGLE_W    = 9;
  localparam int SIDE_W     = 2;
  localparam int SIDE_COUNT = 3;
  localparam int CFG_ADDR_W = 2;

  typedef logic [READ_W-1:0]         reading_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic [SIDE_W-1:0]         side_code_t;
  typedef logic [CFG_ADDR_W-1:0]     cfg_addr_t;

  // Sensor group codes. The fourth code selects no group.
  localparam side_code_t SIDE_LEFT  = 2'd0;
  localparam side_code_t SIDE_RIGHT = 2'd1;
  localparam side_code_t SIDE_FRONT = 2'd2;
  localparam side_code_t SIDE_NONE  = 2'd3;

  // Register indexes on the configuration port.
  localparam cfg_addr_t REG_THR_LEFT  = 2'd0;
  localparam cfg_addr_t REG_THR_RIGHT = 2'd1;
  localparam cfg_addr_t REG_THR_FRONT = 2'd2;

  localparam reading_t THR_RESET = 10'd512;

  // Steering corrections in degrees.
  localparam angle_t ANGLE_LEFT  = -9'sd90;
  localparam angle_t ANGLE_RIGHT = 9'sd90;
  localparam angle_t ANGLE_FRONT = 9'sd180;
  localparam angle_t ANGLE_NONE  = 9'sd0;

  function automatic angle_t side_angle(input side_code_t side);
    angle_t a;
    unique case (side)
      SIDE_LEFT:  a = ANGLE_LEFT;
      SIDE_RIGHT: a = ANGLE_RIGHT;
      SIDE_FRONT: a = ANGLE_FRONT;
      SIDE_NONE:  a = ANGLE_NONE;
    endcase
    return a;
  endfunction

endpackage

// ===== hw/rtl/line_detect_moving_average.sv =====
// Top level of the moving-average line detector for three sensor groups.
// Depends on ldma_pkg, ldma_ram and ldma_eval.
//
// One reading is accepted every clock cycle unless the output stalls, and
// each gives one result via the second stage and the output register. The
// rate is set by the single ring RAM of 3 x AVERAGE_DEPTH entries: the oldest
// entry is read when the reading is accepted and replaced as it leaves the
// second stage, which may share a cycle with the next read, with a bypass for the
// depth-one case. The running totals, write positions and thresholds live
// in flip-flops. The RAM needs no clearing pass after reset: each side has
// a wrap flag, and until its ring has wrapped once the oldest entry reads
// as zero. Side code three changes no state and returns zero.
module line_detect_moving_average #(
  parameter int AVERAGE_DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input stream.
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [15:0]                in_tdata,  // [9:0] reading, rest zero
  input  logic [1:0]                 in_tuser,  // [1:0] side
  // Result stream.
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [15:0]                out_tdata, // [0] on_line, [9:1] correction_angle
  // Configuration writes.
  input  logic                       cfg_wr_en,
  input  ldma_pkg::cfg_addr_t        cfg_addr,
  input  ldma_pkg::reading_t         cfg_wdata
);
  import ldma_pkg::*;

  localparam int LOG_D   = $clog2(AVERAGE_DEPTH);
  localparam int TOTAL_W = READ_W + LOG_D;
  localparam int POS_W   = (AVERAGE_DEPTH > 1) ? LOG_D : 1;
  localparam int RING_D  = SIDE_COUNT * AVERAGE_DEPTH;
  localparam int ADDR_W  = $clog2(RING_D);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(AVERAGE_DEPTH - 1);

  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  // Per-side state.
  reading_t           thr_r   [SIDE_COUNT];
  pos_t               pos_r   [SIDE_COUNT];
  total_t             total_r [SIDE_COUNT];
  logic [SIDE_COUNT-1:0] full_r;

  // Second stage: the accepted reading, aligned with RAM read data.
  logic       s1_v_r;
  side_code_t s1_side_r;
  reading_t   s1_reading_r;
  addr_t      s1_addr_r;
  logic       s1_old_valid_r;
  logic       s1_fwd_r;
  reading_t   s1_fwd_data_r;

  // Output register.
  logic        out_v_r;
  logic [15:0] out_data_r;

  logic       in_acc;
  logic       s1_adv;
  side_code_t in_side;
  reading_t   in_reading;
  logic       in_real;
  logic       s1_real;
  pos_t       in_pos;
  addr_t      rd_addr;
  logic       ram_we;
  reading_t   ram_q;
  reading_t   old_entry;
  total_t     cur_total;
  total_t     new_total;
  reading_t   cur_thr;
  logic       on_line;
  angle_t     angle;
  logic [1:0] s1_idx;
  logic [1:0] in_idx;

  // Handshake: the second stage moves on when the output register is free.
  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign in_side    = in_tuser;
  assign in_reading = in_tdata[READ_W-1:0];
  assign in_real    = (in_side != SIDE_NONE);
  assign s1_real    = (s1_side_r != SIDE_NONE);
  assign in_idx     = in_real ? in_side : SIDE_LEFT;
  assign s1_idx     = s1_real ? s1_side_r : SIDE_LEFT;

  // Ring address of the oldest entry for the incoming side.
  assign in_pos  = pos_r[in_idx];
  assign rd_addr = ADDR_W'(in_idx) * ADDR_W'(AVERAGE_DEPTH) + ADDR_W'(in_pos);
  assign ram_we  = s1_adv && s1_real;

  ldma_ram #(
    .WIDTH (READ_W),
    .DEPTH (RING_D)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (s1_addr_r),
    .wr_data (s1_reading_r),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // Oldest entry: zero until the ring wrapped, bypassed on a same-cycle write.
  always_comb begin
    if (!s1_old_valid_r) begin
      old_entry = '0;
    end else if (s1_fwd_r) begin
      old_entry = s1_fwd_data_r;
    end else begin
      old_entry = ram_q;
    end
  end

  assign cur_total = total_r[s1_idx];
  assign cur_thr   = thr_r[s1_idx];

  ldma_eval #(
    .AVERAGE_DEPTH (AVERAGE_DEPTH)
  ) u_eval (
    .old_entry (old_entry),
    .reading   (s1_reading_r),
    .total     (cur_total),
    .threshold (cur_thr),
    .new_total (new_total),
    .on_line   (on_line)
  );

  assign angle = side_angle(s1_side_r);

  // Write positions and wrap flags advance when a reading with a side is accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SIDE_COUNT; s++) begin
        pos_r[s] <= '0;
      end
      full_r <= '0;
    end else if (in_acc && in_real) begin
      if (in_pos == POS_LAST) begin
        pos_r[in_idx]  <= '0;
        full_r[in_idx] <= 1'b1;
      end else begin
        pos_r[in_idx] <= in_pos + 1'b1;
      end
    end
  end

  // Running totals update as the reading leaves the second stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SIDE_COUNT; s++) begin
        total_r[s] <= '0;
      end
    end else if (ram_we) begin
      total_r[s1_idx] <= new_total;
    end
  end

  // Threshold registers; writes beyond the last index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SIDE_COUNT; s++) begin
        thr_r[s] <= THR_RESET;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_THR_LEFT:  thr_r[0] <= cfg_wdata;
        REG_THR_RIGHT: thr_r[1] <= cfg_wdata;
        REG_THR_FRONT: thr_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Second stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  // Second stage payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_side_r      <= in_side;
      s1_reading_r   <= in_reading;
      s1_addr_r      <= rd_addr;
      s1_old_valid_r <= full_r[in_idx];
      s1_fwd_r       <= ram_we && (s1_addr_r == rd_addr);
      s1_fwd_data_r  <= s1_reading_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= {6'd0, angle, on_line && s1_real};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // A result without a correction angle never reports a line.
  a_none_no_line: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[9:1] == 9'd0)) |-> !out_tdata[0])
    else $error("on_line set for a result without a side");

  // The input side only stalls while the second stage holds a reading.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_v_r && out_v_r && !out_tready))
    else $error("input stalled without a held reading");

  // Once a ring has wrapped, its flag stays set.
  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ((full_r & $past(full_r)) == $past(full_r)))
    else $error("ring wrap flag cleared");

  // A reading with no side leaves the write positions alone.
  a_none_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_side == SIDE_NONE)) |=>
      ($stable(pos_r[0]) && $stable(pos_r[1]) && $stable(pos_r[2])))
    else $error("write position moved for a reading with no side");

endmodule

// ===== hw/rtl/ldma_ram.sv =====
// Generic single-clock RAM, one write port and one read port with
// registered read data. No dependencies.
module ldma_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds while no read is requested.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/ldma_eval.sv =====
// Per-reading evaluation: running total update, moving average and
// line decision. Depends on ldma_pkg.
module ldma_eval #(
  parameter int AVERAGE_DEPTH = 8
) (
  input  ldma_pkg::reading_t                              old_entry,
  input  ldma_pkg::reading_t                              reading,
  input  logic [ldma_pkg::READ_W+$clog2(AVERAGE_DEPTH)-1:0] total,
  input  ldma_pkg::reading_t                              threshold,
  output logic [ldma_pkg::READ_W+$clog2(AVERAGE_DEPTH)-1:0] new_total,
  output logic                                            on_line
);
  import ldma_pkg::*;

  localparam int LOG_D   = $clog2(AVERAGE_DEPTH);
  localparam int TOTAL_W = READ_W + LOG_D;
  // Exact floor division of any TOTAL_W-bit value by a reciprocal.
  localparam int RECIP_SH = TOTAL_W + LOG_D;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int PROD_W   = TOTAL_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + AVERAGE_DEPTH - 1) / AVERAGE_DEPTH);

  logic [TOTAL_W:0]   sum_ext;
  logic [PROD_W-1:0]  prod;
  reading_t           average;
  logic [READ_W:0]    mid_sum;
  reading_t           midpoint;

  // The oldest entry is part of the total, so the difference never wraps.
  assign sum_ext   = {1'b0, total} + (TOTAL_W+1)'(reading) - (TOTAL_W+1)'(old_entry);
  assign new_total = sum_ext[TOTAL_W-1:0];

  // Moving average by multiplication with the depth's reciprocal.
  assign prod    = PROD_W'(new_total) * PROD_W'(RECIP);
  assign average = prod[RECIP_SH +: READ_W];

  // Midpoint of the average and the threshold, rounded down.
  assign mid_sum  = {1'b0, average} + {1'b0, threshold};
  assign midpoint = mid_sum[READ_W:1];
  assign on_line  = (reading > midpoint);

endmodule
